>>> hdl/crcfrm_pkg.sv
// Shared types, constants and the CRC-16/X-25 byte update for the packet framer.
package crcfrm_pkg;

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h8408;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	typedef enum logic [2:0] {
		PH_OPCODE  = 3'b001,
		PH_LENGTH  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       packet_end;
	} result_t;

	// Reflected CRC-16/X-25, one byte, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		logic [7:0]  d;
		c = acc;
		d = b;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

>>> hdl/crcfrm_in_if.sv
// Byte input channel of the packet framer.
interface crcfrm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

>>> hdl/crcfrm_out_if.sv
// Framed result channel of the packet framer.
interface crcfrm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       packet_end;

	modport source (output valid, output out_byte, output last, output packet_end, input ready);
	modport sink   (input valid, input out_byte, input last, input packet_end, output ready);
endinterface

>>> hdl/crc16_x25_packet_framer.sv
// Top level of the CRC-16/X-25 command packet framer.
// Accepts a packet one byte per request: opcode, length, then length payload bytes.
// Each opcode is preceded by the write_address byte (APB register at offset 0), every
// packet byte is passed through, and after the last payload byte (or after a zero
// length byte) the inverted CRC-16/X-25 follows, low byte first, the high byte flagged
// with packet_end. last marks the final result caused by each input byte. The CRC update
// for a byte is done in the accept cycle and its one to three results go into a 4-entry
// result queue; the output drains one result per cycle while out_chan.ready is high.
// An input byte is taken whenever the queue holds at most one result, so in payload a
// byte is taken every cycle unless output stalls; n payload bytes give n + 5 results.
module crc16_x25_packet_framer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [crcfrm_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [crcfrm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [crcfrm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                 pready,
	crcfrm_in_if.sink                            in_chan,
	crcfrm_out_if.source                         out_chan
);

	logic [7:0]              write_address_q;
	crcfrm_pkg::phase_t      phase_q, phase_d;
	logic [7:0]              bytes_left_q, bytes_left_d;
	logic [15:0]             crc_q, crc_d;

	crcfrm_pkg::result_t     queue_q [crcfrm_pkg::Q_DEPTH];
	logic [crcfrm_pkg::Q_PTR_W-1:0] head_q, tail_q;
	logic [crcfrm_pkg::Q_CNT_W-1:0] count_q;

	logic                    cfg_wr, reg_sel;
	logic                    push, pop;
	logic [1:0]              push_n;
	crcfrm_pkg::result_t     res0, res1, res2;
	logic [15:0]             crc_upd, crc_fin;
	logic [7:0]              bl_dec;
	logic [7:0]              b;

	// Configuration port
	assign reg_sel = ~paddr[crcfrm_pkg::APB_ADDR_W-1];
	assign cfg_wr  = psel & penable & pwrite & reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(crcfrm_pkg::APB_DATA_W-8){1'b0}}, write_address_q}
	                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_address_q <= 8'h00;
		end else if (cfg_wr) begin
			write_address_q <= pwdata[7:0];
		end
	end

	// Handshakes
	assign in_chan.ready = (count_q <= crcfrm_pkg::Q_CNT_W'(1));
	assign push          = in_chan.valid & in_chan.ready;
	assign out_chan.valid = (count_q != '0);
	assign pop           = out_chan.valid & out_chan.ready;

	// Framing logic for the accepted byte
	assign b       = in_chan.in_byte;
	assign bl_dec  = bytes_left_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		crc_upd      = crcfrm_pkg::crc_byte(crc_q, b);
		crc_d        = crc_upd;
		crc_fin      = ~crc_upd;
		res0         = '{out_byte: b, last: 1'b1, packet_end: 1'b0};
		res1         = '{out_byte: crc_fin[7:0], last: 1'b0, packet_end: 1'b0};
		res2         = '{out_byte: crc_fin[15:8], last: 1'b1, packet_end: 1'b1};
		push_n       = 2'd1;
		unique case (phase_q)
			crcfrm_pkg::PH_LENGTH: begin
				if (b == 8'd0) begin
					res0.last    = 1'b0;
					push_n       = 2'd3;
					crc_d        = crcfrm_pkg::CRC_PRESET;
					bytes_left_d = 8'd0;
					phase_d      = crcfrm_pkg::PH_OPCODE;
				end else begin
					bytes_left_d = b;
					phase_d      = crcfrm_pkg::PH_PAYLOAD;
				end
			end
			crcfrm_pkg::PH_PAYLOAD: begin
				if (bl_dec == 8'd0) begin
					res0.last    = 1'b0;
					push_n       = 2'd3;
					crc_d        = crcfrm_pkg::CRC_PRESET;
					bytes_left_d = 8'd0;
					phase_d      = crcfrm_pkg::PH_OPCODE;
				end else begin
					bytes_left_d = bl_dec;
				end
			end
			default: begin
				crc_d        = crcfrm_pkg::crc_byte(crcfrm_pkg::CRC_PRESET, b);
				bytes_left_d = 8'd0;
				phase_d      = crcfrm_pkg::PH_LENGTH;
				res0         = '{out_byte: write_address_q, last: 1'b0, packet_end: 1'b0};
				res1         = '{out_byte: b, last: 1'b1, packet_end: 1'b0};
				push_n       = 2'd2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= crcfrm_pkg::PH_OPCODE;
			bytes_left_q <= 8'd0;
			crc_q        <= crcfrm_pkg::CRC_PRESET;
		end else if (push) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			crc_q        <= crc_d;
		end
	end

	// Result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + crcfrm_pkg::Q_PTR_W'(1);
			end
			if (push) begin
				tail_q <= tail_q + crcfrm_pkg::Q_PTR_W'(push_n);
			end
			count_q <= count_q
			         + (push ? crcfrm_pkg::Q_CNT_W'(push_n) : '0)
			         - crcfrm_pkg::Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[tail_q] <= res0;
			if (push_n >= 2'd2) begin
				queue_q[tail_q + crcfrm_pkg::Q_PTR_W'(1)] <= res1;
			end
			if (push_n == 2'd3) begin
				queue_q[tail_q + crcfrm_pkg::Q_PTR_W'(2)] <= res2;
			end
		end
	end

	assign out_chan.out_byte   = queue_q[head_q].out_byte;
	assign out_chan.last       = queue_q[head_q].last;
	assign out_chan.packet_end = queue_q[head_q].packet_end;

endmodule
